/* design/biquad_highpass_filter_macros.svh */
// Assertion macros for the biquad high-pass filter.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef BIQUAD_HIGHPASS_FILTER_MACROS_SVH
`define BIQUAD_HIGHPASS_FILTER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define BQHP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bqhp assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define BQHP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bqhp assertion failed");

`endif

/* design/bqhp_pkg.sv */
// Shared constants for the biquad high-pass filter: register indexes,
// fixed-point formats and defaults. No dependencies.
package bqhp_pkg;

	localparam int COEF_FRAC_BITS_DEF = 30;
	localparam int SAMPLE_W = 16;
	localparam int COEF_W = 32;
	localparam int YH_W = 32;
	localparam int Y_FRAC = 27;
	// x (Q.15) to y history (Q.27) and feedback product alignment
	localparam int Y_ALIGN = Y_FRAC - 15;
	// 32767 = 2^15 - 1
	localparam int OUT_SHIFT = 15;
	// accumulator width; bounded by two 64-bit feedback terms shifted by Y_ALIGN
	localparam int ACC_W = 54;
	localparam int CFG_IDX_W = 3;
	localparam int WARM_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_B0 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_B1 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_B2 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_A1 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_A2 = 3'd5;

	localparam logic [WARM_W-1:0] WARMUP_LEN = 2'd2;

endpackage

/* design/biquad_highpass_filter.sv */
// Channel  | Signals                     | Contents
// s_       | tvalid tready tdata tuser   | in_sample in tdata, restart in tuser
// m_       | tvalid tready tdata         | out_sample in tdata
// cfg_     | we index data               | enable, coef_b0..coef_a2 (index 0..5)
//
// One sample per cycle sustained while the output is not stalled; a sample passes through the
// input register, the accumulator register and the output register in that order.
// The recursion closes in the pass from the input register to the accumulator
// register: the five coefficient products and their sum feed the history.
// Reset clears valids, history, warm-up count, enable and coefficients.
// A stalled output backs up through the full stages; bubbles are filled.
//
// Direct-form-I biquad; depends on bqhp_pkg and biquad_highpass_filter_macros.svh.
`include "biquad_highpass_filter_macros.svh"

module biquad_highpass_filter #(
	parameter int COEF_FRAC_BITS = bqhp_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [15:0]                           s_tdata,   // [15:0] in_sample
	input  logic                                  s_tuser,   // [0] restart
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [15:0]                           m_tdata,   // [15:0] out_sample
	input  logic                                  cfg_we,
	input  logic [bqhp_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [bqhp_pkg::COEF_W-1:0]           cfg_data
);
	import bqhp_pkg::*;

	localparam int YH_SHIFT = COEF_FRAC_BITS + 15 - Y_FRAC;
	localparam int CL_W = COEF_FRAC_BITS + 18;
	localparam int PR_W = COEF_FRAC_BITS + 34;
	localparam int Q_LSB = COEF_FRAC_BITS + 15;
	localparam int Q_W = PR_W - Q_LSB;
	localparam logic signed [ACC_W-1:0] ACC_LIM =
		ACC_W'(64'sd1 <<< (COEF_FRAC_BITS + 16));

	// configuration
	logic                     enable_q;
	logic signed [COEF_W-1:0] coef_b0_q, coef_b1_q, coef_b2_q, coef_a1_q, coef_a2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b0;
			coef_b0_q <= '0;
			coef_b1_q <= '0;
			coef_b2_q <= '0;
			coef_a1_q <= '0;
			coef_a2_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENABLE:  enable_q  <= cfg_data[0];
				REG_COEF_B0: coef_b0_q <= cfg_data;
				REG_COEF_B1: coef_b1_q <= cfg_data;
				REG_COEF_B2: coef_b2_q <= cfg_data;
				REG_COEF_A1: coef_a1_q <= cfg_data;
				REG_COEF_A2: coef_a2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline control
	logic valid_s1, valid_s2, out_valid_q;
	logic out_rdy, s2_rdy, s1_rdy, s1_adv, s2_adv;

	assign out_rdy  = !out_valid_q || m_tready;
	assign s2_rdy   = !valid_s2 || out_rdy;
	assign s1_rdy   = !valid_s1 || s2_rdy;
	assign s1_adv   = valid_s1 && s2_rdy;
	assign s2_adv   = valid_s2 && out_rdy;
	assign s_tready = s1_rdy;

	// input register
	logic signed [SAMPLE_W-1:0] x_s1;
	logic                       restart_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_rdy) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_rdy && s_tvalid) begin
			x_s1       <= s_tdata;
			restart_s1 <= s_tuser;
		end
	end

	// history and filter pass
	logic signed [SAMPLE_W-1:0] x_hist_one_q, x_hist_two_q;
	logic signed [YH_W-1:0]     y_hist_one_q, y_hist_two_q;
	logic [WARM_W-1:0]          warmup_q;

	logic [WARM_W-1:0]          warm;
	logic                       pass;
	logic signed [47:0]         prod_b0, prod_b1, prod_b2;
	logic signed [63:0]         prod_a1, prod_a2;
	logic signed [ACC_W-1:0]    acc_d, ysh;
	logic signed [YH_W-1:0]     y_new, y_seed;

	assign warm    = restart_s1 ? WARMUP_LEN : warmup_q;
	assign pass    = (warm != '0) || !enable_q;
	assign prod_b0 = coef_b0_q * x_s1;
	assign prod_b1 = coef_b1_q * x_hist_one_q;
	assign prod_b2 = coef_b2_q * x_hist_two_q;
	assign prod_a1 = coef_a1_q * y_hist_one_q;
	assign prod_a2 = coef_a2_q * y_hist_two_q;
	assign y_seed  = YH_W'(x_s1) <<< Y_ALIGN;

	always_comb begin
		// feedback terms floor-shifted by the arithmetic shift
		acc_d = ACC_W'(prod_b0) + ACC_W'(prod_b1) + ACC_W'(prod_b2)
			- ACC_W'(prod_a1 >>> Y_ALIGN) - ACC_W'(prod_a2 >>> Y_ALIGN);
		ysh = acc_d >>> YH_SHIFT;
		if (ysh[ACC_W-1:YH_W-1] == '0 || ysh[ACC_W-1:YH_W-1] == '1) begin
			y_new = ysh[YH_W-1:0];
		end else if (ysh[ACC_W-1]) begin
			y_new = {1'b1, {(YH_W-1){1'b0}}};
		end else begin
			y_new = {1'b0, {(YH_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_hist_one_q <= '0;
			x_hist_two_q <= '0;
			y_hist_one_q <= '0;
			y_hist_two_q <= '0;
			warmup_q     <= '0;
		end else if (s1_adv) begin
			x_hist_two_q <= x_hist_one_q;
			x_hist_one_q <= x_s1;
			y_hist_two_q <= y_hist_one_q;
			y_hist_one_q <= pass ? y_seed : y_new;
			warmup_q     <= (warm != '0) ? warm - 1'b1 : '0;
		end
	end

	// accumulator register
	logic signed [ACC_W-1:0]    acc_s2;
	logic signed [SAMPLE_W-1:0] x_s2;
	logic                       pass_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_rdy) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			acc_s2  <= acc_d;
			x_s2    <= x_s1;
			pass_s2 <= pass;
		end
	end

	// output scaling: clamp, times 32767, truncate toward zero, saturate
	logic signed [ACC_W-1:0] acc_cl_full;
	logic signed [CL_W-1:0]  acc_cl;
	logic signed [PR_W-1:0]  prod_o;
	logic [PR_W-1:0]         mag;
	logic [Q_W-1:0]          q;
	logic                    neg;
	logic [SAMPLE_W-1:0]     res;

	always_comb begin
		if (acc_s2 > ACC_LIM) begin
			acc_cl_full = ACC_LIM;
		end else if (acc_s2 < -ACC_LIM) begin
			acc_cl_full = -ACC_LIM;
		end else begin
			acc_cl_full = acc_s2;
		end
		acc_cl = acc_cl_full[CL_W-1:0];
		prod_o = (PR_W'(acc_cl) <<< OUT_SHIFT) - PR_W'(acc_cl);
		neg    = prod_o[PR_W-1];
		mag    = neg ? PR_W'(-prod_o) : PR_W'(prod_o);
		q      = mag[PR_W-1:Q_LSB];
		if (neg) begin
			res = (q > Q_W'(32768)) ? 16'h8000 : 16'(~q[SAMPLE_W-1:0] + 1'b1);
		end else begin
			res = (q > Q_W'(32767)) ? 16'h7fff : q[SAMPLE_W-1:0];
		end
	end

	// output register
	logic [SAMPLE_W-1:0] out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_rdy) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			out_data_q <= pass_s2 ? x_s2 : res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	`BQHP_ASSERT_NXT(a_restart_warm, clk, arst_n, s1_adv && restart_s1, warmup_q == 2'd1 && pass_s2)
	`BQHP_ASSERT_NXT(a_pass_seed, clk, arst_n, s1_adv && pass, y_hist_one_q == $past(y_seed))
	`BQHP_ASSERT_NXT(a_pass_out, clk, arst_n, s2_adv && pass_s2, out_data_q == $past(x_s2))
	`BQHP_ASSERT_IMP(a_stall_backs_up, clk, arst_n, out_valid_q && !m_tready && valid_s2 && valid_s1, !s_tready)

endmodule

/* tb/tb_biquad_highpass_filter.sv */
// Self-checking testbench for biquad_highpass_filter: directed and random sample
// streams on the s_/m_ stream ports, coefficient loads on the cfg_ write port.
// Depends on bqhp_pkg and the design files; expected samples come from a local model.
`timescale 1ns / 1ps

module tb_biquad_highpass_filter;
	import bqhp_pkg::*;

	localparam int  COEF_FRAC  = COEF_FRAC_BITS_DEF;
	localparam int  ACC_TO_YH  = COEF_FRAC + 15 - Y_FRAC;
	localparam int  OUT_DIV    = COEF_FRAC + 15;
	localparam longint OUT_GAIN = (longint'(1) <<< OUT_SHIFT) - 1;
	localparam longint ACC_LIM  = longint'(1) <<< (COEF_FRAC + 16);
	localparam longint YH_MAX   = (longint'(1) <<< (YH_W - 1)) - 1;
	localparam longint YH_MIN   = -(longint'(1) <<< (YH_W - 1));

	// indexes past the register map; writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	localparam int FLT_BUTTER  = 0;
	localparam int FLT_WILD    = 1;
	localparam int FLT_EXTREME = 2;
	localparam int FLT_BYPASS  = 3;

	localparam int SET_KEEP    = 0;
	localparam int SET_GAIN2   = 1;
	localparam int SET_EXTREME = 2;
	localparam int SET_BUTTER  = 3;
	localparam int SET_BYPASS  = 4;

	localparam int NUM_PHASES      = 8;
	localparam int ITEMS_PER_PHASE = 200;
	localparam int PRESSURE_PHASE  = 6;
	localparam int STALL_LEN       = 80;
	localparam int SETTLE_CYCLES   = 8;
	localparam int TIMEOUT_NS      = 3_000_000;
	localparam int DIR_ROWS        = 25;

	// nominal Butterworth high-pass, fc/fs about 1/48, Q2.30
	localparam logic signed [COEF_W-1:0] BW_B0 = 32'sd978702000;
	localparam logic signed [COEF_W-1:0] BW_B1 = -32'sd1957404000;
	localparam logic signed [COEF_W-1:0] BW_B2 = 32'sd978702000;
	localparam logic signed [COEF_W-1:0] BW_A1 = -32'sd1949151000;
	localparam logic signed [COEF_W-1:0] BW_A2 = 32'sd891976000;

	typedef struct {
		logic                       en;
		logic signed [COEF_W-1:0]   b0, b1, b2, a1, a2;
	} filter_set_t;

	typedef struct {
		int                         set_sel;
		logic signed [SAMPLE_W-1:0] smp;
		logic                       restart;
		logic                       known;
		logic signed [SAMPLE_W-1:0] gold;
	} sample_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [15:0]           s_tdata;   // [15:0] in_sample
	logic                  s_tuser;   // [0] restart
	logic                  m_tvalid;
	logic                  m_tready;
	logic [15:0]           m_tdata;   // [15:0] out_sample
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [COEF_W-1:0]     cfg_data;

	int send_idle_pct = 13;
	int recv_idle_pct = 50;
	int stall_cycles  = 0;
	int mismatches    = 0;

	logic signed [SAMPLE_W-1:0] expected_out_q [$];

	// model copy of registers and filter history
	filter_set_t                live_set = '{1'b0, '0, '0, '0, '0, '0};
	logic signed [SAMPLE_W-1:0] x_d1 = '0, x_d2 = '0;
	logic signed [YH_W-1:0]     y_d1 = '0, y_d2 = '0;
	logic [WARM_W-1:0]          warmup_cnt = '0;

	filter_set_t directed_sets [5] = '{
		'{1'b0, '0, '0, '0, '0, '0},
		'{1'b1, 32'sh7FFF_FFFF, '0, '0, '0, '0},
		'{1'b1, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
			32'sh7FFF_FFFF},
		'{1'b1, BW_B0, BW_B1, BW_B2, BW_A1, BW_A2},
		'{1'b0, BW_B0, BW_B1, BW_B2, BW_A1, BW_A2}
	};

	sample_row_t directed_rows [DIR_ROWS] = '{
		// reset state: filter off, samples pass straight through
		'{SET_KEEP,    16'sd0,      1'b0, 1'b1, 16'sd0},
		'{SET_KEEP,    16'sh7FFF,   1'b0, 1'b1, 16'sh7FFF},
		'{SET_KEEP,    16'sh8000,   1'b0, 1'b1, 16'sh8000},
		'{SET_KEEP,    -16'sd1,     1'b1, 1'b1, -16'sd1},
		'{SET_KEEP,    16'sd1,      1'b0, 1'b1, 16'sd1},
		// gain near 2: two warm-up samples, then saturation both ways
		'{SET_GAIN2,   16'sd100,    1'b1, 1'b1, 16'sd100},
		'{SET_KEEP,    -16'sd200,   1'b0, 1'b1, -16'sd200},
		'{SET_KEEP,    16'sh7FFF,   1'b0, 1'b1, 16'sh7FFF},
		'{SET_KEEP,    16'sh8000,   1'b0, 1'b1, 16'sh8000},
		'{SET_KEEP,    16'sd0,      1'b0, 1'b1, 16'sd0},
		// extreme coefficients drive the y history into saturation
		'{SET_EXTREME, 16'sh7FFF,   1'b1, 1'b1, 16'sh7FFF},
		'{SET_KEEP,    16'sh8000,   1'b0, 1'b1, 16'sh8000},
		'{SET_KEEP,    16'sh7FFF,   1'b0, 1'b0, 16'sd0},
		'{SET_KEEP,    16'sh8000,   1'b0, 1'b0, 16'sd0},
		'{SET_KEEP,    16'sh7FFF,   1'b0, 1'b0, 16'sd0},
		'{SET_KEEP,    16'sd0,      1'b0, 1'b0, 16'sd0},
		// ordinary high-pass, restart in mid-stream
		'{SET_BUTTER,  16'sd1000,   1'b1, 1'b1, 16'sd1000},
		'{SET_KEEP,    -16'sd1000,  1'b0, 1'b1, -16'sd1000},
		'{SET_KEEP,    16'sd5000,   1'b0, 1'b0, 16'sd0},
		'{SET_KEEP,    -16'sd7000,  1'b0, 1'b0, 16'sd0},
		'{SET_KEEP,    16'sd12000,  1'b1, 1'b1, 16'sd12000},
		'{SET_KEEP,    16'sd3,      1'b0, 1'b1, 16'sd3},
		'{SET_KEEP,    16'sd20000,  1'b0, 1'b0, 16'sd0},
		// coefficients loaded but filter off
		'{SET_BYPASS,  16'sh8000,   1'b0, 1'b1, 16'sh8000},
		'{SET_KEEP,    16'sh7FFF,   1'b0, 1'b1, 16'sh7FFF}
	};

	biquad_highpass_filter uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Advance the model by one sample and return the filtered output.
	function automatic logic signed [SAMPLE_W-1:0] highpass_next(
		input logic signed [SAMPLE_W-1:0] x, input logic restart);
		longint acc, yh, prod, q;
		logic signed [SAMPLE_W-1:0] y;
		if (restart)
			warmup_cnt = WARMUP_LEN;
		if (warmup_cnt != 0 || !live_set.en) begin
			if (warmup_cnt != 0)
				warmup_cnt--;
			y = x;
			yh = longint'(x) <<< Y_ALIGN;
		end else begin
			acc = longint'(live_set.b0) * longint'(x)
				+ longint'(live_set.b1) * longint'(x_d1)
				+ longint'(live_set.b2) * longint'(x_d2);
			acc -= (longint'(live_set.a1) * longint'(y_d1)) >>> Y_ALIGN;
			acc -= (longint'(live_set.a2) * longint'(y_d2)) >>> Y_ALIGN;

			yh = acc >>> ACC_TO_YH;
			if (yh > YH_MAX) yh = YH_MAX;
			if (yh < YH_MIN) yh = YH_MIN;

			if (acc > ACC_LIM) acc = ACC_LIM;
			if (acc < -ACC_LIM) acc = -ACC_LIM;
			prod = acc * OUT_GAIN;
			// truncate toward zero, then clamp to 16 bits
			if (prod < 0) begin
				q = (-prod) >>> OUT_DIV;
				y = (q > 32767) ? 16'sh8000 : SAMPLE_W'(-q);
			end else begin
				q = prod >>> OUT_DIV;
				y = (q > 32767) ? 16'sh7FFF : SAMPLE_W'(q);
			end
		end
		x_d2 = x_d1;
		x_d1 = x;
		y_d2 = y_d1;
		y_d1 = YH_W'(yh);
		return y;
	endfunction

	function automatic logic signed [COEF_W-1:0] jitter(input logic signed [COEF_W-1:0] v);
		return v + $signed($urandom_range(0, 2097151)) - 32'sd1048576;
	endfunction

	function automatic logic signed [COEF_W-1:0] extreme_coef();
		case ($urandom_range(2))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			default: return '0;
		endcase
	endfunction

	function automatic filter_set_t pick_filter(input int kind);
		filter_set_t c;
		c.en = 1'b1;
		case (kind)
			FLT_BUTTER: begin
				c.b0 = jitter(BW_B0);
				c.b1 = jitter(BW_B1);
				c.b2 = jitter(BW_B2);
				c.a1 = jitter(BW_A1);
				c.a2 = jitter(BW_A2);
			end
			FLT_EXTREME: begin
				c.b0 = extreme_coef();
				c.b1 = extreme_coef();
				c.b2 = extreme_coef();
				c.a1 = extreme_coef();
				c.a2 = extreme_coef();
			end
			default: begin
				c.en = (kind != FLT_BYPASS);
				c.b0 = $urandom();
				c.b1 = $urandom();
				c.b2 = $urandom();
				c.a1 = $urandom();
				c.a2 = $urandom();
			end
		endcase
		return c;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(3))
					0: return 16'sh7FFF;
					1: return 16'sh8000;
					2: return -16'sd1;
					default: return 16'sd0;
				endcase
			end
			1, 2: return $signed(SAMPLE_W'($urandom_range(0, 511))) - 16'sd256;
			default: return SAMPLE_W'($urandom());
		endcase
	endfunction

	// Call at a rising edge; leaves cfg_we high for the next write.
	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		case (idx)
			REG_ENABLE:  live_set.en = d[0];
			REG_COEF_B0: live_set.b0 = d;
			REG_COEF_B1: live_set.b1 = d;
			REG_COEF_B2: live_set.b2 = d;
			REG_COEF_A1: live_set.a1 = d;
			REG_COEF_A2: live_set.a2 = d;
			default: ;
		endcase
	endtask

	task automatic load_filter(input filter_set_t c);
		logic [COEF_W-1:0] en_word;
		en_word = $urandom();
		en_word[0] = c.en;
		put_reg(REG_ENABLE, en_word);
		put_reg(REG_COEF_B0, c.b0);
		put_reg(REG_COEF_B1, c.b1);
		put_reg(REG_COEF_B2, c.b2);
		put_reg(REG_COEF_A1, c.a1);
		put_reg(REG_COEF_A2, c.a2);
		put_reg(REG_SPARE_6, $urandom());
		put_reg(REG_SPARE_7, $urandom());
		cfg_we <= 1'b0;
	endtask

	// Offer one sample; valid stays high after the transfer so back-to-back
	// samples never toggle it within one step.
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp, input logic restart,
		input logic known, input logic signed [SAMPLE_W-1:0] gold);
		logic signed [SAMPLE_W-1:0] predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= smp;
		s_tuser  <= restart;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predicted = highpass_next(smp, restart);
		expected_out_q.push_back(known ? gold : predicted);
	endtask

	// Hold the input idle until every output has come back.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_out_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// output side: random backpressure plus an occasional long hold-off
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_cycles > 0) begin
				stall_cycles--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// compare every output transfer with the oldest expected sample
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				if (expected_out_q.size() == 0) begin
					$error("out_sample: expected none, got %0d", $signed(m_tdata));
					mismatches++;
				end else if ($signed(m_tdata) !== expected_out_q[0]) begin
					$error("out_sample: expected %0d, got %0d", expected_out_q[0],
						$signed(m_tdata));
					mismatches++;
					void'(expected_out_q.pop_front());
				end else begin
					void'(expected_out_q.pop_front());
				end
			end
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("** biquad_highpass_filter: FAILED **");
		$finish;
	end

	initial begin
		int kind;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_ENABLE;
		cfg_data  = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].set_sel != SET_KEEP) begin
				drain();
				load_filter(directed_sets[directed_rows[i].set_sel]);
			end
			send_sample(directed_rows[i].smp, directed_rows[i].restart,
				directed_rows[i].known, directed_rows[i].gold);
		end

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain();
			send_idle_pct = (ph < 3) ? 13 : (ph < 6) ? 50 : 0;
			recv_idle_pct = (ph < 3) ? 50 : (ph < 6) ? 13 : 0;
			if (ph == 5)
				kind = FLT_BYPASS;
			else if (ph % 2 == 0)
				kind = FLT_BUTTER;
			else
				kind = (ph % 4 == 1) ? FLT_WILD : FLT_EXTREME;
			load_filter(pick_filter(kind));
			// block the output while samples keep coming so the pipe backs up
			if (ph == PRESSURE_PHASE)
				stall_cycles = STALL_LEN;
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_sample(pick_sample(), (n == 0) || ($urandom_range(99) < 3), 1'b0, '0);
		end
		drain();

		if (mismatches == 0)
			$display("** biquad_highpass_filter: PASSED **");
		else
			$display("** biquad_highpass_filter: FAILED **");
		$finish;
	end

endmodule
